// ===== rtl/scbc_pkg.sv =====
// Package for the tiled sparse layout converter.
// Holds sizing constants, request codes and the transaction payload structs.
// No dependencies.
package scbc_pkg;

  localparam int TILE_EDGE     = 64;
  localparam int MAX_TILE_ROWS = 32;
  localparam int MAX_TILE_COLS = 32;
  localparam int MAX_NONZEROS  = 65536;
  localparam int NUM_TILES     = MAX_TILE_ROWS * MAX_TILE_COLS;
  localparam int COUNT_MAX     = 8191;

  localparam int TS     = $clog2(TILE_EDGE);
  localparam int TILE_W = $clog2(NUM_TILES);
  localparam int CNT_W  = 13;
  localparam int TOT_W  = $clog2(MAX_NONZEROS + 1);
  localparam int RS_W   = 18;
  localparam int DS_W   = 17;
  localparam int DIM_W  = 12;
  localparam int TR_W   = DIM_W - TS + 1;
  localparam int HT_W   = TS + 1;
  localparam int THR_W  = 7;

  typedef enum logic [1:0] {
    REQ_COUNT    = 2'd0,
    REQ_FINALIZE = 2'd1,
    REQ_PLACE    = 2'd2,
    REQ_READ     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_THR  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] row;
    logic [10:0] col;
    logic [31:0] value_bits;
    logic [9:0]  tile_select;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [9:0]  tile_index;
    logic [15:0] data_slot;
    logic [5:0]  local_col;
    logic [31:0] value_out;
    logic [16:0] row_info_addr;
    logic        row_info_inc;
    logic [5:0]  local_row;
    logic        tile_is_csr;
    logic [16:0] row_start;
    logic [15:0] data_start;
    logic [16:0] total_length;
  } out_t;

  typedef struct packed {
    logic            csr;
    logic [RS_W-1:0] rs;
    logic [DS_W-1:0] ds;
  } desc_t;

endpackage

// ===== rtl/sparse_csr_to_blocked_converter_unit.sv =====
// Top level of the tiled sparse layout converter: sequencer, tile tables, output register.
// Depends on scbc_pkg.
//
// Usage: requests enter on in_valid/in_stall/in_data, one result transaction
// leaves on out_valid/out_stall/out_data for every request. The user must
// write registers matrix_rows, matrix_cols and fill_threshold through cfg_we,
// cfg_index and cfg_wdata only while the block is idle; the block does not enforce it.
// Count, place and read pass through S_ADDR, which checks range and addresses
// the tile tables, and S_EXEC, for the registered table read and
// read-modify-write; the result then sits in the output register. A request
// that fails the range check goes from S_ADDR straight to the output register.
// Finalize walks every tile of the grid, in S_FRD (table read), then S_FWR
// (type and prefix update), and after the last tile puts the total length in
// the output register and raises out_valid.
// One request is in flight at a time; in_stall stays high until the result
// is taken. A stalled result holds in the output register.
// After reset the count and placement tables are cleared by a pass over all
// 1024 tiles, one tile a cycle, during which in_stall is high; the block
// starts in the counting phase and only reset returns it there.
module sparse_csr_to_blocked_converter_unit
  import scbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_wdata
);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_ADDR = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_FRD  = 7'b0010000,
    S_FWR  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] rows_r, cols_r;
  logic [THR_W-1:0] thr_r;
  logic             phase_r, phase_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  in_t              in_r;
  out_t             out_r, out_nxt;
  logic [TILE_W-1:0] t_r, t_nxt;
  logic [TR_W-1:0]  fr_r, fr_nxt, fc_r, fc_nxt;
  logic [RS_W-1:0]  rs_r, rs_nxt;
  logic [DS_W-1:0]  ds_r, ds_nxt;
  logic [TILE_W-1:0] idx_r, idx_nxt;

  logic [CNT_W-1:0] cnt_mem [NUM_TILES];
  logic [CNT_W-1:0] plc_mem [NUM_TILES];
  desc_t            dsc_mem [NUM_TILES];
  logic [CNT_W-1:0] cnt_rd_r, plc_rd_r;
  desc_t            dsc_rd_r;

  logic              cnt_we, plc_we, dsc_we;
  logic [TILE_W-1:0] cnt_wa, plc_wa, dsc_wa, cnt_ra, plc_ra, dsc_ra;
  logic [CNT_W-1:0]  cnt_wd, plc_wd;
  desc_t             dsc_wd;

  logic [TR_W-1:0]   tr, tc;
  logic              grid_ok;
  logic [2*TR_W-1:0] nt;
  logic [2*TR_W:0]   idx_full;
  logic [DIM_W-1:0]  h_full;
  logic [HT_W-1:0]   h;
  logic [HT_W+THR_W-1:0] need;
  logic              f_csr, f_last;
  logic [RS_W-1:0]   rs_add;
  logic [RS_W:0]     addr_sum;
  logic [DS_W-1:0]   slot_sum;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  always_comb begin
    tr = TR_W'((13'(rows_r) + 13'(TILE_EDGE - 1)) >> TS);
    tc = TR_W'((13'(cols_r) + 13'(TILE_EDGE - 1)) >> TS);
    grid_ok = (rows_r != '0) && (cols_r != '0) &&
              (tr <= TR_W'(MAX_TILE_ROWS)) && (tc <= TR_W'(MAX_TILE_COLS));
    nt = tr * tc;
    idx_full = (2*TR_W+1)'(TR_W'(in_r.row >> TS) * tc) + (2*TR_W+1)'(in_r.col >> TS);
    h_full = rows_r - DIM_W'({fr_r, TS'(0)});
    h = (h_full > DIM_W'(TILE_EDGE)) ? HT_W'(TILE_EDGE) : HT_W'(h_full);
    need = h * thr_r;
    f_csr = (14'(cnt_rd_r) >= 14'(need));
    rs_add = f_csr ? RS_W'(h) : RS_W'(cnt_rd_r);
    f_last = (fr_r == tr - 1'b1) && (fc_r == tc - 1'b1);
    addr_sum = (RS_W+1)'(dsc_rd_r.rs) +
               (dsc_rd_r.csr ? (RS_W+1)'(in_r.row[TS-1:0]) : (RS_W+1)'(plc_rd_r));
    slot_sum = dsc_rd_r.ds + DS_W'(plc_rd_r);
  end

  always_comb begin
    cnt_ra = (state_r == S_FRD) ? t_r : idx_nxt;
    plc_ra = idx_nxt;
    dsc_ra = (in_r.req_type == REQ_READ) ? in_r.tile_select : idx_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    total_nxt = total_r;
    out_nxt   = out_r;
    t_nxt     = t_r;
    fr_nxt    = fr_r;
    fc_nxt    = fc_r;
    rs_nxt    = rs_r;
    ds_nxt    = ds_r;
    idx_nxt   = idx_r;
    cnt_we = 1'b0; cnt_wa = idx_r; cnt_wd = cnt_rd_r + 1'b1;
    plc_we = 1'b0; plc_wa = idx_r; plc_wd = plc_rd_r + 1'b1;
    dsc_we = 1'b0; dsc_wa = t_r;   dsc_wd = '{csr: f_csr, rs: rs_r, ds: ds_r};
    unique case (state_r)
      S_CLR: begin
        cnt_we = 1'b1; cnt_wa = t_r; cnt_wd = '0;
        plc_we = 1'b1; plc_wa = t_r; plc_wd = '0;
        t_nxt = t_r + 1'b1;
        if (t_r == TILE_W'(NUM_TILES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_ADDR;
      end
      S_ADDR: begin
        out_nxt = '0;
        out_nxt.status = 1'b1;
        idx_nxt = TILE_W'(idx_full);
        state_nxt = S_OUT;
        case (in_r.req_type) inside
          REQ_COUNT, REQ_PLACE: begin
            if (grid_ok && (12'(in_r.row) < rows_r) && (12'(in_r.col) < cols_r) &&
                (idx_full < (2*TR_W+1)'(NUM_TILES))) state_nxt = S_EXEC;
          end
          REQ_FINALIZE: begin
            if (grid_ok && !phase_r) begin
              t_nxt = '0; fr_nxt = '0; fc_nxt = '0; rs_nxt = '0; ds_nxt = '0;
              state_nxt = S_FRD;
            end
          end
          default: begin
            if (grid_ok && phase_r && ((2*TR_W)'(in_r.tile_select) < nt))
              state_nxt = S_EXEC;
          end
        endcase
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        case (in_r.req_type)
          REQ_COUNT: begin
            if (!phase_r && (total_r < TOT_W'(MAX_NONZEROS)) &&
                (cnt_rd_r < CNT_W'(COUNT_MAX))) begin
              cnt_we = 1'b1;
              total_nxt = total_r + 1'b1;
              out_nxt.status = 1'b0;
              out_nxt.tile_index = idx_r;
            end
          end
          REQ_PLACE: begin
            if (phase_r && (plc_rd_r < cnt_rd_r)) begin
              plc_we = 1'b1;
              out_nxt.status        = 1'b0;
              out_nxt.tile_index    = idx_r;
              out_nxt.data_slot     = slot_sum[15:0];
              out_nxt.local_col     = in_r.col[TS-1:0];
              out_nxt.value_out     = in_r.value_bits;
              out_nxt.row_info_addr = (addr_sum > 19'd131071) ? 17'h1FFFF : addr_sum[16:0];
              out_nxt.row_info_inc  = dsc_rd_r.csr;
              out_nxt.local_row     = in_r.row[TS-1:0];
              out_nxt.tile_is_csr   = dsc_rd_r.csr;
              out_nxt.row_start     = dsc_rd_r.rs[17] ? 17'h1FFFF : dsc_rd_r.rs[16:0];
              out_nxt.data_start    = dsc_rd_r.ds[16] ? 16'hFFFF : dsc_rd_r.ds[15:0];
            end
          end
          default: begin
            out_nxt.status      = 1'b0;
            out_nxt.tile_index  = in_r.tile_select;
            out_nxt.tile_is_csr = dsc_rd_r.csr;
            out_nxt.row_start   = dsc_rd_r.rs[17] ? 17'h1FFFF : dsc_rd_r.rs[16:0];
            out_nxt.data_start  = dsc_rd_r.ds[16] ? 16'hFFFF : dsc_rd_r.ds[15:0];
          end
        endcase
      end
      S_FRD: begin
        state_nxt = S_FWR;
      end
      S_FWR: begin
        dsc_we = 1'b1;
        plc_we = 1'b1; plc_wa = t_r; plc_wd = '0;
        rs_nxt = rs_r + rs_add;
        ds_nxt = ds_r + DS_W'(cnt_rd_r);
        t_nxt  = t_r + 1'b1;
        if (fc_r == tc - 1'b1) begin
          fc_nxt = '0;
          fr_nxt = fr_r + 1'b1;
        end else begin
          fc_nxt = fc_r + 1'b1;
        end
        if (f_last) begin
          phase_nxt = 1'b1;
          out_nxt.status = 1'b0;
          out_nxt.total_length = rs_nxt[17] ? 17'h1FFFF : rs_nxt[16:0];
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_FRD;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_r <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (plc_we) plc_mem[plc_wa] <= plc_wd;
    plc_rd_r <= plc_mem[plc_ra];
  end

  always_ff @(posedge clk) begin
    if (dsc_we) dsc_mem[dsc_wa] <= dsc_wd;
    dsc_rd_r <= dsc_mem[dsc_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      phase_r <= 1'b0;
      total_r <= '0;
      t_r     <= '0;
      rows_r  <= DIM_W'(2048);
      cols_r  <= DIM_W'(2048);
      thr_r   <= THR_W'(1);
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      total_r <= total_nxt;
      t_r     <= t_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS: rows_r <= cfg_wdata;
          CFG_COLS: cols_r <= cfg_wdata;
          CFG_THR:  thr_r  <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) in_r <= in_data;
    out_r  <= out_nxt;
    fr_r   <= fr_nxt;
    fc_r   <= fc_nxt;
    rs_r   <= rs_nxt;
    ds_r   <= ds_nxt;
    idx_r  <= idx_nxt;
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the tiled sparse layout converter.
// Drives count, finalize, place and read transactions with random idle and
// stall gaps, and checks every result against an in-bench layout predictor or a fixed expected value.
// Depends on scbc_pkg and sparse_csr_to_blocked_converter_unit.
`timescale 1ns / 1ps

module tb_top;
  import scbc_pkg::*;

  typedef struct {
    in_t  stim;
    bit   fixed;
    out_t want;
  } table_row_t;

  typedef struct {
    bit   on;
    out_t v;
  } fixed_t;

  typedef struct {
    logic [10:0] row;
    logic [10:0] col;
  } entry_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [DIM_W-1:0] cfg_wdata = '0;

  int unsigned grid_rows = 2048, grid_cols = 2048, csr_thr = 1;
  int unsigned tile_count [NUM_TILES];
  bit          tile_type [NUM_TILES];
  int unsigned tile_row_start [NUM_TILES];
  int unsigned tile_data_start [NUM_TILES];
  int unsigned tile_placed [NUM_TILES];
  bit          placing = 1'b0;
  int unsigned total_count = 0;

  out_t   expected_q[$];
  fixed_t fixed_q[$];
  entry_t counted_q[$];
  int     mismatch_count = 0;
  int     idle_cycles = 0;
  bit     quiet = 1'b0;
  int     stall_left = 0;

  sparse_csr_to_blocked_converter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned sat(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic out_t layout_step(in_t x);
    out_t r;
    int unsigned tr, tc, idx, h, rs, ds, lr, lc, placed, addr, t;
    bit csr;
    r = '0;
    r.status = 1'b1;
    idx = 0;
    if (grid_rows == 0 || grid_cols == 0) return r;
    tr = (grid_rows + TILE_EDGE - 1) / TILE_EDGE;
    tc = (grid_cols + TILE_EDGE - 1) / TILE_EDGE;
    if (tr > MAX_TILE_ROWS || tc > MAX_TILE_COLS) return r;
    if (x.req_type == REQ_COUNT || x.req_type == REQ_PLACE) begin
      if (x.row >= grid_rows || x.col >= grid_cols) return r;
      idx = (x.row / TILE_EDGE) * tc + x.col / TILE_EDGE;
      if (idx >= NUM_TILES) return r;
    end
    case (req_t'(x.req_type))
      REQ_COUNT: begin
        if (placing) return r;
        if (total_count >= MAX_NONZEROS || tile_count[idx] >= COUNT_MAX) return r;
        tile_count[idx]++;
        total_count++;
        counted_q.push_back('{x.row, x.col});
        r.status = 1'b0;
        r.tile_index = 10'(idx);
      end
      REQ_FINALIZE: begin
        if (placing) return r;
        rs = 0;
        ds = 0;
        for (int unsigned tile_r = 0; tile_r < tr; tile_r++) begin
          h = grid_rows - tile_r * TILE_EDGE;
          if (h > TILE_EDGE) h = TILE_EDGE;
          for (int unsigned tile_c = 0; tile_c < tc; tile_c++) begin
            t = tile_r * tc + tile_c;
            csr = tile_count[t] >= h * csr_thr;
            tile_type[t] = csr;
            tile_row_start[t] = rs;
            tile_data_start[t] = ds;
            tile_placed[t] = 0;
            rs += csr ? h : tile_count[t];
            ds += tile_count[t];
          end
        end
        placing = 1'b1;
        r.status = 1'b0;
        r.total_length = 17'(sat(rs, 131071));
      end
      REQ_PLACE: begin
        if (!placing) return r;
        placed = tile_placed[idx];
        if (placed >= tile_count[idx]) return r;
        csr = tile_type[idx];
        lr = x.row % TILE_EDGE;
        lc = x.col % TILE_EDGE;
        addr = tile_row_start[idx] + (csr ? lr : placed);
        tile_placed[idx] = placed + 1;
        r.status = 1'b0;
        r.tile_index = 10'(idx);
        r.data_slot = 16'(tile_data_start[idx] + placed);
        r.local_col = 6'(lc);
        r.value_out = x.value_bits;
        r.row_info_addr = 17'(sat(addr, 131071));
        r.row_info_inc = csr;
        r.local_row = 6'(lr);
        r.tile_is_csr = csr;
        r.row_start = 17'(sat(tile_row_start[idx], 131071));
        r.data_start = 16'(sat(tile_data_start[idx], 65535));
      end
      default: begin
        if (!placing || x.tile_select >= tr * tc) return r;
        r.status = 1'b0;
        r.tile_index = x.tile_select;
        r.tile_is_csr = tile_type[x.tile_select];
        r.row_start = 17'(sat(tile_row_start[x.tile_select], 131071));
        r.data_start = 16'(sat(tile_data_start[x.tile_select], 65535));
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic out_t error_result();
    out_t r;
    r = '0;
    r.status = 1'b1;
    return r;
  endfunction

  function automatic out_t count_result(int unsigned t);
    out_t r;
    r = '0;
    r.tile_index = 10'(t);
    return r;
  endfunction

  function automatic in_t make_req(req_t k, int unsigned row, int unsigned col);
    in_t x;
    x.req_type = k;
    x.row = 11'(row);
    x.col = 11'(col);
    x.value_bits = $urandom;
    x.tile_select = 10'($urandom);
    return x;
  endfunction

  task automatic send(in_t x, bit fixed = 1'b0, out_t want = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    fixed_q.push_back('{fixed, want});
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t k, int unsigned v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= k;
    cfg_wdata <= DIM_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_count(bit hot);
    in_t x;
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      x = in_t'(66'({$urandom, $urandom, $urandom}));
      x.value_bits = $urandom;
      if (x.req_type == REQ_FINALIZE) x.req_type = REQ_READ;
    end else if (hot && r < 70) begin
      x = make_req(REQ_COUNT, $urandom_range(0, 63), $urandom_range(0, 63));
    end else begin
      x = make_req(REQ_COUNT, $urandom_range(0, grid_rows - 1),
                   $urandom_range(0, grid_cols - 1));
    end
    send(x);
  endtask

  task automatic random_place();
    in_t x;
    entry_t e;
    int r;
    r = $urandom_range(0, 99);
    if (r < 78 && counted_q.size() != 0) begin
      e = counted_q[$urandom_range(0, counted_q.size() - 1)];
      x = make_req(REQ_PLACE, e.row, e.col);
    end else if (r < 90) begin
      x = make_req(REQ_READ, 0, 0);
      if ($urandom_range(0, 3) != 0) x.tile_select = 10'($urandom_range(0, 40));
    end else begin
      x = in_t'(66'({$urandom, $urandom, $urandom}));
      x.value_bits = $urandom;
    end
    send(x);
  endtask

  always @(posedge clk) begin
    fixed_t f;
    out_t want;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROWS: grid_rows = 32'(cfg_wdata);
        CFG_COLS: grid_cols = 32'(cfg_wdata);
        CFG_THR:  csr_thr = 32'(cfg_wdata[THR_W-1:0]);
        default: ;
      endcase
    end
    if (in_valid && !in_stall) begin
      f = fixed_q.pop_front();
      want = layout_step(in_data);
      expected_q.push_back(f.on ? f.v : want);
    end
    if (out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $realtime, out_data);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch expected %p", $realtime, want);
          $display("%0t:          actual   %p", $realtime, out_data);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 599) == 0) quiet <= ~quiet;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    table_row_t dir_table[$];
    out_t ok;
    ok = '0;
    dir_table = '{
      '{make_req(REQ_PLACE, 0, 0), 1'b1, error_result()},
      '{make_req(REQ_READ, 0, 0), 1'b1, error_result()},
      '{make_req(REQ_COUNT, 0, 0), 1'b1, count_result(0)},
      '{make_req(REQ_COUNT, 2047, 2047), 1'b1, count_result(1023)},
      '{make_req(REQ_COUNT, 64, 63), 1'b1, count_result(32)},
      '{make_req(REQ_COUNT, 0, 2047), 1'b1, count_result(31)},
      '{make_req(REQ_COUNT, 2047, 0), 1'b1, count_result(992)},
      '{make_req(REQ_COUNT, 1365, 682), 1'b0, ok},
      '{make_req(REQ_COUNT, 682, 1365), 1'b0, ok},
      '{make_req(REQ_COUNT, 63, 63), 1'b0, ok},
      '{make_req(REQ_COUNT, 1, 2), 1'b0, ok},
      '{make_req(REQ_COUNT, 5, 9), 1'b0, ok}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) send(dir_table[i].stim, dir_table[i].fixed, dir_table[i].want);

    write_reg(CFG_THR, 64);
    write_reg(CFG_ROWS, 0);
    send(make_req(REQ_COUNT, 0, 0), 1'b1, error_result());
    write_reg(CFG_ROWS, 4095);
    send(make_req(REQ_COUNT, 0, 0), 1'b1, error_result());
    write_reg(CFG_ROWS, 2048);
    write_reg(CFG_COLS, 4095);
    send(make_req(REQ_COUNT, 0, 0), 1'b1, error_result());
    write_reg(CFG_ROWS, 1);
    write_reg(CFG_COLS, 1);
    send(make_req(REQ_COUNT, 0, 0), 1'b1, count_result(0));
    send(make_req(REQ_COUNT, 1, 0), 1'b1, error_result());
    send(make_req(REQ_COUNT, 0, 1), 1'b1, error_result());

    for (int s = 0; s < 3; s++) begin
      write_reg(CFG_ROWS, $urandom_range(1, 2048));
      write_reg(CFG_COLS, $urandom_range(1, 2048));
      repeat (250) random_count(1'b0);
    end

    write_reg(CFG_ROWS, $urandom_range(65, 400));
    write_reg(CFG_COLS, $urandom_range(65, 400));
    write_reg(CFG_THR, $urandom_range(0, 3));
    repeat (320) random_count(1'b1);

    send(make_req(REQ_FINALIZE, 0, 0));
    send(make_req(REQ_FINALIZE, 0, 0), 1'b1, error_result());
    send(make_req(REQ_COUNT, 0, 0), 1'b1, error_result());

    repeat (700) random_place();

    write_reg(CFG_COLS, $urandom_range(1, grid_cols));
    write_reg(CFG_THR, 0);
    repeat (60) random_place();

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
